/* src/ctks_pkg.sv */
package ctks_pkg;

  // Ticks per second; the half-second blink falls at half of it.
  localparam int unsigned TICKS_PER_SECOND = 10;
  localparam int unsigned TICK_W           = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned HALF_TICKS       = TICKS_PER_SECOND / 2;

  localparam int unsigned SEC_W  = 6;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned ROLL_W = 8;
  localparam int unsigned SEG_W  = 8;

  localparam logic [SEC_W:0]  SEC_WRAP    = 7'd60;
  localparam logic [MIN_W:0]  MIN_WRAP    = 7'd60;
  localparam logic [MIN_W:0]  MIN_CAPTURE = 7'd30;
  localparam logic [HOUR_W:0] HOUR_WRAP   = 6'd24;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'hff;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_LOAD = 1'b1
  } func_e;

  typedef logic [SEG_W-1:0] seg_t;

  // Tens digit of a value below 64, by comparison.
  function automatic logic [2:0] tens_of(input logic [5:0] value);
    logic [2:0] tens;
    if (value >= 6'd60) begin
      tens = 3'd6;
    end else if (value >= 6'd50) begin
      tens = 3'd5;
    end else if (value >= 6'd40) begin
      tens = 3'd4;
    end else if (value >= 6'd30) begin
      tens = 3'd3;
    end else if (value >= 6'd20) begin
      tens = 3'd2;
    end else if (value >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    return tens;
  endfunction

  // Units digit: value minus ten times its tens digit.
  function automatic logic [3:0] units_of(input logic [5:0] value);
    logic [2:0] tens;
    logic [5:0] ten_x;
    logic [5:0] rem;
    tens  = tens_of(value);
    ten_x = {tens, 3'b000} + {2'b00, tens, 1'b0};
    rem   = value - ten_x;
    return rem[3:0];
  endfunction

  // Active-low segment pattern of one digit; anything else is blank.
  function automatic seg_t seg_of(input logic [3:0] digit);
    seg_t seg;
    case (digit)
      4'd0:    seg = 8'h08;
      4'd1:    seg = 8'h7c;
      4'd2:    seg = 8'h11;
      4'd3:    seg = 8'h30;
      4'd4:    seg = 8'h64;
      4'd5:    seg = 8'h22;
      4'd6:    seg = 8'h02;
      4'd7:    seg = 8'h78;
      4'd8:    seg = 8'h00;
      4'd9:    seg = 8'h20;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

/* src/clock_time_keeper_segment.sv */
// 24-hour time-of-day keeper with a seven-segment display image. Each input
// item is either a tick (func 0, one 100 ms step) or a load (func 1, sets
// hours, minutes and seconds and clears the sub-second count). Every item
// gives exactly one result item: a blink pulse for the seconds LED (twice a
// second, held off while capture is enabled), a capture request when a
// minute rollover lands on minute 30 or 60, a refresh flag on loads and
// minute rollovers, four active-low segment bytes of the time after the
// item (a leading hour zero shows blank, 0xff) and the wrapping count of
// minute rollovers since reset. The counter
// cascade updates at the accepting edge and the result sits in a single
// output register, so a new item is taken every cycle while the result is
// either free or being taken in the same cycle.
module clock_time_keeper_segment (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic                          capture_enabled_i,
  input  logic [ctks_pkg::HOUR_W-1:0]   load_hours_i,
  input  logic [ctks_pkg::MIN_W-1:0]    load_minutes_i,
  input  logic [ctks_pkg::SEC_W-1:0]    load_seconds_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          led_toggle_o,
  output logic                          capture_request_o,
  output logic                          refresh_o,
  output ctks_pkg::seg_t                seg_hour_tens_o,
  output ctks_pkg::seg_t                seg_hour_units_o,
  output ctks_pkg::seg_t                seg_minute_tens_o,
  output ctks_pkg::seg_t                seg_minute_units_o,
  output logic [ctks_pkg::ROLL_W-1:0]   minutes_counted_o
);

  localparam int unsigned TW = ctks_pkg::TICK_W;

  // Time-of-day state.
  logic [TW-1:0]                  tick_q, tick_d;
  logic [ctks_pkg::SEC_W-1:0]     sec_q, sec_d;
  logic [ctks_pkg::MIN_W-1:0]     min_q, min_d;
  logic [ctks_pkg::HOUR_W-1:0]    hour_q, hour_d;
  logic [ctks_pkg::ROLL_W-1:0]    roll_q, roll_d;

  // Result register flags.
  logic out_valid_q, out_valid_d;
  logic led_q, led_d;
  logic capreq_q, capreq_d;
  logic refresh_q, refresh_d;

  logic in_accept;

  // Cascade sums, one bit wider than the counters.
  logic [TW:0]                  tick_sum;
  logic [ctks_pkg::SEC_W:0]     sec_sum;
  logic [ctks_pkg::MIN_W:0]     min_sum;
  logic [ctks_pkg::HOUR_W:0]    hour_sum;
  logic                         sec_carry;
  logic                         min_carry;
  logic                         hour_carry;
  logic                         day_wrap;

  // Hold the input while a result waits and the far side stalls.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign tick_sum = {1'b0, tick_q} + {{TW{1'b0}}, 1'b1};
  assign sec_sum  = {1'b0, sec_q} + {{ctks_pkg::SEC_W{1'b0}}, 1'b1};
  assign min_sum  = {1'b0, min_q} + {{ctks_pkg::MIN_W{1'b0}}, 1'b1};
  assign hour_sum = {1'b0, hour_q} + {{ctks_pkg::HOUR_W{1'b0}}, 1'b1};

  assign sec_carry  = tick_sum >= (TW + 1)'(ctks_pkg::TICKS_PER_SECOND);
  assign min_carry  = sec_carry & (sec_sum >= ctks_pkg::SEC_WRAP);
  assign hour_carry = min_carry & (min_sum >= ctks_pkg::MIN_WRAP);
  assign day_wrap   = hour_sum >= ctks_pkg::HOUR_WRAP;

  // Next state and result flags for the item at the input.
  always_comb begin
    tick_d    = tick_q;
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    roll_d    = roll_q;
    led_d     = led_q;
    capreq_d  = capreq_q;
    refresh_d = refresh_q;
    if (in_accept) begin
      if (ctks_pkg::func_e'(func_i) == ctks_pkg::FUNC_LOAD) begin
        // Load: take the new time, restart the sub-second count.
        tick_d    = '0;
        sec_d     = load_seconds_i;
        min_d     = load_minutes_i;
        hour_d    = load_hours_i;
        led_d     = 1'b0;
        capreq_d  = 1'b0;
        refresh_d = 1'b1;
      end else begin
        // Tick: blink at the half and full second.
        led_d = ~capture_enabled_i &
                ((tick_sum == (TW + 1)'(ctks_pkg::HALF_TICKS)) ||
                 (tick_sum == (TW + 1)'(ctks_pkg::TICKS_PER_SECOND)));
        capreq_d  = min_carry & ((min_sum == ctks_pkg::MIN_CAPTURE) ||
                                 (min_sum == ctks_pkg::MIN_WRAP));
        refresh_d = min_carry;
        tick_d    = sec_carry ? '0 : tick_sum[TW-1:0];
        if (sec_carry) begin
          sec_d = min_carry ? '0 : sec_sum[ctks_pkg::SEC_W-1:0];
        end
        if (min_carry) begin
          roll_d = roll_q + {{(ctks_pkg::ROLL_W-1){1'b0}}, 1'b1};
          min_d  = hour_carry ? '0 : min_sum[ctks_pkg::MIN_W-1:0];
        end
        if (hour_carry) begin
          hour_d = day_wrap ? '0 : hour_sum[ctks_pkg::HOUR_W-1:0];
        end
      end
    end
  end

  // Result valid: set on accept, drop once taken.
  always_comb begin
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      sec_q       <= '0;
      min_q       <= '0;
      hour_q      <= '0;
      roll_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tick_q      <= tick_d;
      sec_q       <= sec_d;
      min_q       <= min_d;
      hour_q      <= hour_d;
      roll_q      <= roll_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    led_q     <= led_d;
    capreq_q  <= capreq_d;
    refresh_q <= refresh_d;
  end

  // The time registers change only on accept, which also loads the result,
  // so the display bytes decoded from them always match the held result.
  ctks_seg_decode u_seg_decode (
    .hours_i            (hour_q),
    .minutes_i          (min_q),
    .seg_hour_tens_o    (seg_hour_tens_o),
    .seg_hour_units_o   (seg_hour_units_o),
    .seg_minute_tens_o  (seg_minute_tens_o),
    .seg_minute_units_o (seg_minute_units_o)
  );

  assign out_valid_o       = out_valid_q;
  assign led_toggle_o      = led_q;
  assign capture_request_o = capreq_q;
  assign refresh_o         = refresh_q;
  assign minutes_counted_o = roll_q;

endmodule

/* src/ctks_seg_decode.sv */
// Turn the held time of day into four display bytes.
module ctks_seg_decode (
  input  logic [ctks_pkg::HOUR_W-1:0] hours_i,
  input  logic [ctks_pkg::MIN_W-1:0]  minutes_i,
  output ctks_pkg::seg_t              seg_hour_tens_o,
  output ctks_pkg::seg_t              seg_hour_units_o,
  output ctks_pkg::seg_t              seg_minute_tens_o,
  output ctks_pkg::seg_t              seg_minute_units_o
);

  logic [5:0] hours_ext;
  logic [2:0] hour_tens;

  assign hours_ext = {1'b0, hours_i};
  assign hour_tens = ctks_pkg::tens_of(hours_ext);

  // Blank a leading zero of the hour.
  assign seg_hour_tens_o    = (hour_tens == 3'd0) ? ctks_pkg::SEG_BLANK
                                                  : ctks_pkg::seg_of({1'b0, hour_tens});
  assign seg_hour_units_o   = ctks_pkg::seg_of(ctks_pkg::units_of(hours_ext));
  assign seg_minute_tens_o  = ctks_pkg::seg_of({1'b0, ctks_pkg::tens_of(minutes_i)});
  assign seg_minute_units_o = ctks_pkg::seg_of(ctks_pkg::units_of(minutes_i));

endmodule
